>>> hdl/sparse_set_membership_top_defines.svh
// ----------------------------------------------------------------------------
// Sparse set membership: assertion macros
// Shared concurrent assertion forms, clocked on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_SET_MEMBERSHIP_TOP_DEFINES_SVH
`define SPARSE_SET_MEMBERSHIP_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ant.
`define SSM_ASSERT_NOW(label, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ant.
`define SSM_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// Sparse set membership package
// Sizes, request codes and the beat and memory port types of the block.
// ----------------------------------------------------------------------------
package ssm_pkg;

    // Id space and field widths
    localparam int ID_SPACE = 1024;
    localparam int ID_W     = 10;
    localparam int COUNT_W  = 11;
    localparam int REQ_W    = 2;

    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(ID_SPACE);
    localparam logic [ID_W-1:0]    ID_LAST    = ID_W'(ID_SPACE - 1);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

    // Request beat
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [ID_W-1:0]  member_id;
    } req_t;

    // Result beat
    typedef struct packed {
        logic               ok;
        logic [ID_W-1:0]    slot;
        logic [COUNT_W-1:0] member_count;
    } result_t;

    // One RAM's write and read address controls
    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        logic [ID_W-1:0] wdata;
        logic [ID_W-1:0] raddr;
    } mem_port_t;

endpackage

>>> hdl/sparse_set_membership_top.sv
// ----------------------------------------------------------------------------
// Sparse set membership top level
// Sparse set over ids 0..1023: add, remove and find with slot and count.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req (req_type, member_id) and raise start; the
//   beat is taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with result (ok,
//   slot, member_count) valid; the receiver must take it in that cycle.
//   Steps: an accepted request reads the slot map (S_MAP), then the
//   dense list (S_DENSE); done and the result follow from S_DENSE, or
//   from S_LAST on a successful remove. busy falls with done, so a new
//   request can be taken at the edge that ends the result cycle, and none
//   while one is in flight. The order is set by two dependent RAM reads
//   (slot map, then dense list), plus a third dense read on remove.
//   Reset: the count clears at once; then the slot map is zeroed one
//   entry per cycle, with busy high and no request taken.
//   The receiver cannot stall the result channel.
// ----------------------------------------------------------------------------
module sparse_set_membership_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ssm_pkg::req_t     req,
    output logic              busy,
    output logic              done,
    output ssm_pkg::result_t  result
);

    import ssm_pkg::*;

    mem_port_t       map_port;
    mem_port_t       dense_port;
    logic [ID_W-1:0] map_rdata;
    logic [ID_W-1:0] dense_rdata;

    // Request sequencer
    ssm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req         (req),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .map_port    (map_port),
        .map_rdata   (map_rdata),
        .dense_port  (dense_port),
        .dense_rdata (dense_rdata)
    );

    // Slot map: id to dense slot
    ssm_ram #(
        .WIDTH (ID_W),
        .DEPTH (ID_SPACE)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_port.we),
        .waddr (map_port.waddr),
        .wdata (map_port.wdata),
        .raddr (map_port.raddr),
        .rdata (map_rdata)
    );

    // Dense list: packed member ids
    ssm_ram #(
        .WIDTH (ID_W),
        .DEPTH (ID_SPACE)
    ) u_dense_ram (
        .clk   (clk),
        .we    (dense_port.we),
        .waddr (dense_port.waddr),
        .wdata (dense_port.wdata),
        .raddr (dense_port.raddr),
        .rdata (dense_rdata)
    );

endmodule

>>> hdl/ssm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ssm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ssm_engine.sv
// ----------------------------------------------------------------------------
// Sparse set membership engine
// Sequencer that clears the slot map after reset, then for each request
// reads the map and dense list; a successful add or remove writes both.
// ----------------------------------------------------------------------------
`include "sparse_set_membership_top_defines.svh"

module ssm_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  ssm_pkg::req_t               req,
    output logic                        busy,
    output logic                        done,
    output ssm_pkg::result_t            result,
    output ssm_pkg::mem_port_t          map_port,
    input  logic [ssm_pkg::ID_W-1:0]    map_rdata,
    output ssm_pkg::mem_port_t          dense_port,
    input  logic [ssm_pkg::ID_W-1:0]    dense_rdata
);

    import ssm_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MAP   = 6'b000100,
        S_DENSE = 6'b001000,
        S_LAST  = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t             state_reg,  state_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [ID_W-1:0]    clr_reg,    clr_next;
    logic               done_reg,   done_next;
    req_t               req_reg,    req_next;
    logic [ID_W-1:0]    slot_reg,   slot_next;
    result_t            result_reg, result_next;
    logic               hit;

    // Membership test: map slot is live and the dense entry points back
    assign hit = ({1'b0, slot_reg} < count_reg) && (dense_rdata == req_reg.member_id);

    // Sequence one request through the two memories
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        req_next    = req_reg;
        slot_next   = slot_reg;
        result_next = result_reg;
        map_port    = '0;
        dense_port  = '0;
        case (state_reg)
            S_CLEAR:
            begin
                map_port.we    = 1'b1;
                map_port.waddr = clr_reg;
                map_port.wdata = '0;
                clr_next       = clr_reg + ID_W'(1);
                if (clr_reg == ID_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                map_port.raddr = req.member_id;
                if (start)
                begin
                    req_next   = req;
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                slot_next        = map_rdata;
                dense_port.raddr = map_rdata;
                state_next       = S_DENSE;
            end
            S_DENSE:
            begin
                // Fetch the last dense entry in case a remove needs it
                dense_port.raddr         = ID_W'(count_reg - COUNT_W'(1));
                state_next               = S_IDLE;
                done_next                = 1'b1;
                result_next.ok           = 1'b0;
                result_next.slot         = '0;
                result_next.member_count = count_reg;
                case (req_reg.req_type)
                    REQ_ADD:
                    begin
                        if (hit)
                        begin
                            result_next.slot = slot_reg;
                        end
                        else if (count_reg != COUNT_FULL)
                        begin
                            // Append at the tail and point the map at it
                            dense_port.we            = 1'b1;
                            dense_port.waddr         = ID_W'(count_reg);
                            dense_port.wdata         = req_reg.member_id;
                            map_port.we              = 1'b1;
                            map_port.waddr           = req_reg.member_id;
                            map_port.wdata           = ID_W'(count_reg);
                            count_next               = count_reg + COUNT_W'(1);
                            result_next.ok           = 1'b1;
                            result_next.slot         = ID_W'(count_reg);
                            result_next.member_count = count_reg + COUNT_W'(1);
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (hit)
                        begin
                            state_next = S_LAST;
                            done_next  = 1'b0;
                        end
                    end
                    REQ_FIND:
                    begin
                        if (hit)
                        begin
                            result_next.ok   = 1'b1;
                            result_next.slot = slot_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_LAST:
            begin
                // Move the last entry into the freed slot and fix its map
                dense_port.we            = 1'b1;
                dense_port.waddr         = slot_reg;
                dense_port.wdata         = dense_rdata;
                map_port.we              = 1'b1;
                map_port.waddr           = dense_rdata;
                map_port.wdata           = slot_reg;
                count_next               = count_reg - COUNT_W'(1);
                state_next               = S_IDLE;
                done_next                = 1'b1;
                result_next.ok           = 1'b1;
                result_next.slot         = slot_reg;
                result_next.member_count = count_reg - COUNT_W'(1);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            count_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    // Payload holding registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        slot_reg   <= slot_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `SSM_ASSERT_NEXT(a_done_single, done_reg, !done_reg, "result strobe lasted two cycles")
    `SSM_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE, "result shown while busy")
    `SSM_ASSERT_NOW(a_count_range, 1'b1, count_reg <= COUNT_FULL, "member count past id space")
    `SSM_ASSERT_NEXT(a_accept_map, start && (state_reg == S_IDLE), state_reg == S_MAP,
        "accepted beat did not start a map read")
    `SSM_ASSERT_NEXT(a_remove_dec, state_reg == S_LAST,
        count_reg == $past(count_reg) - COUNT_W'(1), "remove did not drop the count by one")

endmodule
